// ===== rtl/satq_pkg.sv =====
`default_nettype none
package satq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int DL_W = 62;
	localparam int ENTRY_W = DL_W + 8 + 1 + 16;
	localparam logic [29:0] NSEC_LIMIT = 30'd1000000000;

	localparam logic [1:0] CMD_POST = 2'd0;
	localparam logic [1:0] CMD_EXPIRE = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	localparam logic [2:0] ST_QUEUED = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_DUE_NOW = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_EXPIRED = 3'd4;
	localparam logic [2:0] ST_CANCELLED = 3'd5;
	localparam logic [2:0] ST_NOT_FOUND = 3'd6;
	localparam logic [2:0] ST_NONE_DUE = 3'd7;

	typedef struct packed {
		logic [1:0] command;
		logic [31:0] now_sec;
		logic [29:0] now_nsec;
		logic [31:0] alarm_sec;
		logic [29:0] alarm_nsec;
		logic [1:0] alarm_mode;
		logic alarm_kind;
		logic [7:0] alarm_tag;
		logic [15:0] cancel_handle;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] result_tag;
		logic result_kind;
		logic [15:0] result_handle;
		logic [31:0] time_sec;
		logic [29:0] time_nsec;
		logic next_valid;
		logic [31:0] next_sec;
		logic [29:0] next_nsec;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [7:0] tag;
		logic kind;
		logic [15:0] handle;
	} entry_t;

endpackage
`default_nettype wire

// ===== rtl/satq_ram.sv =====
`default_nettype none
module satq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/sorted_alarm_timer_queue.sv =====
// Sorted alarm timer queue.
// Requests arrive on req (req_valid/req_ready) as one satq_pkg::req_t; results
// leave on rsp (rsp_valid/rsp_ready) as satq_pkg::rsp_t, with last marking the
// final result of a request. The block handles one request at a time and
// drops req_ready while it works. Entries live in a RAM in deadline order
// and a single 62-bit compare unit walks them via one read and one write port.
// A post first checks the request, then reads and compares entries to find
// its place and moves the entries behind it up one place each to open a gap.
// A cancel walks until the handle matches and then shifts the tail down.
// An expire pops the head entry per result, and shifts the queue down by one
// each time, so each popped result costs a walk over the queue.
// Results are held in an output register; while the receiver stalls the
// sequencer simply waits, so nothing is lost. Request 3 is taken and ignored.
// After reset the queue is empty and the handle counter is zero; the RAM is
// not cleared, since data read from unoccupied entries is never used.
`default_nettype none
module sorted_alarm_timer_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire satq_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output satq_pkg::rsp_t rsp
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SCAN_RD = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_UP_RD = 4'd4;
	localparam logic [3:0] S_UP_WR = 4'd5;
	localparam logic [3:0] S_INS = 4'd6;
	localparam logic [3:0] S_DN_RD = 4'd7;
	localparam logic [3:0] S_DN_WR = 4'd8;
	localparam logic [3:0] S_HEAD_RD = 4'd9;
	localparam logic [3:0] S_HEAD = 4'd10;
	localparam logic [3:0] S_EMIT = 4'd11;
	localparam logic [3:0] S_WAIT = 4'd12;

	localparam int IW = satq_pkg::IDX_W;
	localparam int OW = satq_pkg::OCC_W;

	logic [3:0] state_q;
	satq_pkg::req_t req_q;
	logic [OW-1:0] occ_q;
	logic [15:0] hnd_q;
	logic [OW-1:0] idx_q;
	logic [satq_pkg::CNT_W-1:0] cnt_q;
	logic [satq_pkg::DL_W-1:0] dl_q;
	logic [satq_pkg::DL_W-1:0] head_q;
	satq_pkg::entry_t hit_q;
	logic [2:0] pend_st_q;
	logic pend_last_q;
	logic head_rdy_q;
	satq_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic emit_now;

	logic we;
	logic [IW-1:0] waddr, raddr;
	satq_pkg::entry_t wdata, rdata;

	satq_ram #(.WIDTH(satq_pkg::ENTRY_W), .DEPTH(satq_pkg::QUEUE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Shared compare unit: a <= b on 62-bit times.
	logic [satq_pkg::DL_W-1:0] cmp_a, cmp_b;
	logic cmp_le;
	assign cmp_le = cmp_a <= cmp_b;

	logic [satq_pkg::DL_W-1:0] now_t;
	assign now_t = {req_q.now_sec, req_q.now_nsec};

	// Relative-time adder.
	logic [30:0] ns_sum;
	logic [29:0] ns_fix;
	logic [31:0] s_fix;
	logic carry;
	assign ns_sum = {1'b0, req_q.alarm_nsec} + {1'b0, req_q.now_nsec};
	assign carry = ns_sum >= {1'b0, satq_pkg::NSEC_LIMIT};
	assign ns_fix = carry ? 30'(ns_sum - {1'b0, satq_pkg::NSEC_LIMIT}) : ns_sum[29:0];
	assign s_fix = req_q.alarm_sec + req_q.now_sec + {31'd0, carry};

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// A result is loaded once the head entry is on rdata and the output is free.
	assign emit_now = (state_q == S_EMIT) && head_rdy_q && (!rsp_valid_q || rsp_ready);

	always_comb begin
		we = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata;
		raddr = idx_q[IW-1:0];
		cmp_a = rdata.deadline;
		cmp_b = dl_q;
		case (state_q)
			S_WAIT: begin
				cmp_a = dl_q;
				cmp_b = now_t;
			end
			S_UP_RD: raddr = IW'(idx_q - OW'(1));
			S_UP_WR: we = 1'b1;
			S_INS: begin
				we = 1'b1;
				wdata = '{deadline: dl_q, tag: req_q.alarm_tag,
					kind: req_q.alarm_kind, handle: hnd_q};
			end
			S_DN_RD: raddr = IW'(idx_q + OW'(1));
			S_DN_WR: we = 1'b1;
			S_HEAD: cmp_b = now_t;
			S_EMIT: begin
				raddr = '0;
				cmp_b = now_t;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			hnd_q <= '0;
			rsp_valid_q <= 1'b0;
			head_rdy_q <= 1'b0;
		end else begin
			if (emit_now) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						idx_q <= '0;
						cnt_q <= '0;
						case (req.command)
							satq_pkg::CMD_POST: state_q <= S_CHECK;
							satq_pkg::CMD_EXPIRE: state_q <= S_HEAD_RD;
							satq_pkg::CMD_CANCEL: state_q <= S_SCAN_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CHECK: begin
					hit_q <= '{deadline: '0, tag: req_q.alarm_tag,
						kind: req_q.alarm_kind, handle: 16'd0};
					pend_last_q <= 1'b1;
					if (req_q.alarm_mode[1] || req_q.alarm_nsec >= satq_pkg::NSEC_LIMIT) begin
						pend_st_q <= satq_pkg::ST_INVALID;
						state_q <= S_EMIT;
					end else begin
						if (req_q.alarm_mode[0]) begin
							dl_q <= {s_fix, ns_fix};
						end else begin
							dl_q <= {req_q.alarm_sec, req_q.alarm_nsec};
						end
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (cmp_le) begin
						pend_st_q <= satq_pkg::ST_DUE_NOW;
						state_q <= S_EMIT;
					end else if (occ_q >= OW'(satq_pkg::QUEUE_DEPTH)) begin
						pend_st_q <= satq_pkg::ST_FULL;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (idx_q >= occ_q) begin
						if (req_q.command == satq_pkg::CMD_POST) begin
							head_q <= {occ_q, {(satq_pkg::DL_W-OW){1'b0}}};
							idx_q <= occ_q;
							state_q <= S_UP_RD;
						end else begin
							hit_q <= '{deadline: '0, tag: 8'd0, kind: 1'b0,
								handle: req_q.cancel_handle};
							pend_st_q <= satq_pkg::ST_NOT_FOUND;
							pend_last_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (req_q.command == satq_pkg::CMD_POST) begin
						if (cmp_le) begin
							idx_q <= idx_q + OW'(1);
							state_q <= S_SCAN_RD;
						end else begin
							cnt_q <= satq_pkg::CNT_W'(0);
							dl_q <= dl_q;
							head_q <= {idx_q, {(satq_pkg::DL_W-OW){1'b0}}};
							idx_q <= occ_q;
							state_q <= S_UP_RD;
						end
					end else if (rdata.handle == req_q.cancel_handle) begin
						hit_q <= '{deadline: '0, tag: rdata.tag, kind: rdata.kind,
							handle: req_q.cancel_handle};
						pend_st_q <= satq_pkg::ST_CANCELLED;
						pend_last_q <= 1'b1;
						state_q <= S_DN_RD;
					end else begin
						idx_q <= idx_q + OW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_UP_RD: begin
					// head_q top bits hold the insert position during a post.
					if (idx_q == head_q[satq_pkg::DL_W-1 -: OW] || idx_q == '0) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					idx_q <= idx_q - OW'(1);
					state_q <= S_UP_RD;
				end
				S_INS: begin
					occ_q <= occ_q + OW'(1);
					hnd_q <= hnd_q + 16'd1;
					hit_q <= '{deadline: '0, tag: req_q.alarm_tag,
						kind: req_q.alarm_kind, handle: hnd_q};
					pend_st_q <= satq_pkg::ST_QUEUED;
					pend_last_q <= 1'b1;
					state_q <= S_EMIT;
				end
				S_DN_RD: begin
					if (idx_q + OW'(1) >= occ_q) begin
						occ_q <= occ_q - OW'(1);
						idx_q <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					idx_q <= idx_q + OW'(1);
					state_q <= S_DN_RD;
				end
				S_HEAD_RD: begin
					idx_q <= '0;
					if (occ_q == '0 || cnt_q == satq_pkg::CNT_W'(satq_pkg::MAX_RESULTS)) begin
						if (cnt_q == '0) begin
							hit_q <= '0;
							pend_st_q <= satq_pkg::ST_NONE_DUE;
							pend_last_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (cmp_le) begin
						hit_q <= '{deadline: '0, tag: rdata.tag, kind: rdata.kind,
							handle: rdata.handle};
						pend_st_q <= satq_pkg::ST_EXPIRED;
						cnt_q <= cnt_q + satq_pkg::CNT_W'(1);
						state_q <= S_DN_RD;
					end else if (cnt_q == '0) begin
						hit_q <= '0;
						pend_st_q <= satq_pkg::ST_NONE_DUE;
						pend_last_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					// The first cycle reads the head entry; the result goes out
					// once that entry is on rdata and the output register is free.
					if (!head_rdy_q) begin
						head_rdy_q <= 1'b1;
					end else if (emit_now) begin
						head_rdy_q <= 1'b0;
						rsp_q.status <= pend_st_q;
						rsp_q.result_tag <= hit_q.tag;
						rsp_q.result_kind <= hit_q.kind;
						rsp_q.result_handle <= hit_q.handle;
						if (pend_st_q == satq_pkg::ST_QUEUED) begin
							{rsp_q.time_sec, rsp_q.time_nsec} <= dl_q;
						end else begin
							{rsp_q.time_sec, rsp_q.time_nsec} <= now_t;
						end
						rsp_q.next_valid <= (occ_q != '0);
						{rsp_q.next_sec, rsp_q.next_nsec} <=
							(occ_q != '0) ? rdata.deadline : '0;
						if (pend_st_q == satq_pkg::ST_EXPIRED) begin
							// Last when the pop limit is hit, the queue is empty,
							// or the new head is not yet due.
							if (cnt_q == satq_pkg::CNT_W'(satq_pkg::MAX_RESULTS)
								|| occ_q == '0 || !cmp_le) begin
								rsp_q.last <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								rsp_q.last <= 1'b0;
								state_q <= S_HEAD_RD;
							end
						end else begin
							rsp_q.last <= pend_last_q;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A taken request starts the sequencer unless it is the unused command.
	// Occupancy never exceeds the depth, and a stalled result holds steady.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready || req_q.command == satq_pkg::CMD_IGNORED)
		else $error("sequencer did not start on request");
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(satq_pkg::QUEUE_DEPTH))
		else $error("occupancy above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== tb/sv/satq_checker.sv =====
`timescale 1ns / 100ps
module satq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire satq_pkg::req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire satq_pkg::rsp_t rsp,
	output int fail_count,
	output int pending_count
);
	import satq_pkg::*;

	// Shadow copy of the alarm queue, kept in deadline order.
	entry_t alarm_q[$];
	logic [15:0] handle_ctr;
	rsp_t expected_rsp[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic rsp_t make_rsp(logic [2:0] st, logic [7:0] tag, logic k,
			logic [15:0] h, logic [61:0] t);
		rsp_t r;
		r = '0;
		r.status = st;
		r.result_tag = tag;
		r.result_kind = k;
		r.result_handle = h;
		r.time_sec = t[61:30];
		r.time_nsec = t[29:0];
		if (alarm_q.size() > 0) begin
			r.next_valid = 1'b1;
			r.next_sec = alarm_q[0].deadline[61:30];
			r.next_nsec = alarm_q[0].deadline[29:0];
		end
		return r;
	endfunction

	task automatic predict_alarm_results(input req_t q);
		logic [61:0] now_t;
		logic [61:0] dl;
		logic [32:0] sec_sum;
		logic [30:0] ns_sum;
		entry_t e;
		rsp_t r;
		int i;
		int n;
		now_t = {q.now_sec, q.now_nsec};
		case (q.command)
			CMD_POST: begin
				if (q.alarm_mode[1] || q.alarm_nsec >= NSEC_LIMIT) begin
					r = make_rsp(ST_INVALID, q.alarm_tag, q.alarm_kind, 16'd0, now_t);
				end else begin
					dl = {q.alarm_sec, q.alarm_nsec};
					if (q.alarm_mode[0]) begin
						// Nanosecond carry at most once; seconds wrap.
						ns_sum = {1'b0, q.alarm_nsec} + {1'b0, q.now_nsec};
						sec_sum = {1'b0, q.alarm_sec} + {1'b0, q.now_sec};
						if (ns_sum >= {1'b0, NSEC_LIMIT}) begin
							ns_sum = ns_sum - {1'b0, NSEC_LIMIT};
							sec_sum = sec_sum + 33'd1;
						end
						dl = {sec_sum[31:0], ns_sum[29:0]};
					end
					if (dl <= now_t)
						r = make_rsp(ST_DUE_NOW, q.alarm_tag, q.alarm_kind, 16'd0, now_t);
					else if (alarm_q.size() >= QUEUE_DEPTH)
						r = make_rsp(ST_FULL, q.alarm_tag, q.alarm_kind, 16'd0, now_t);
					else begin
						i = 0;
						while (i < alarm_q.size() && alarm_q[i].deadline <= dl)
							i++;
						e.deadline = dl;
						e.tag = q.alarm_tag;
						e.kind = q.alarm_kind;
						e.handle = handle_ctr;
						alarm_q.insert(i, e);
						r = make_rsp(ST_QUEUED, q.alarm_tag, q.alarm_kind, handle_ctr, dl);
						handle_ctr++;
					end
				end
				r.last = 1'b1;
				expected_rsp.push_back(r);
			end
			CMD_EXPIRE: begin
				n = 0;
				while (n < MAX_RESULTS && alarm_q.size() > 0 && alarm_q[0].deadline <= now_t)
				begin
					e = alarm_q.pop_front();
					r = make_rsp(ST_EXPIRED, e.tag, e.kind, e.handle, now_t);
					r.last = !(n < MAX_RESULTS - 1 && alarm_q.size() > 0 &&
						alarm_q[0].deadline <= now_t);
					expected_rsp.push_back(r);
					n++;
				end
				if (n == 0) begin
					r = make_rsp(ST_NONE_DUE, 8'd0, 1'b0, 16'd0, now_t);
					r.last = 1'b1;
					expected_rsp.push_back(r);
				end
			end
			CMD_CANCEL: begin
				i = 0;
				while (i < alarm_q.size() && alarm_q[i].handle != q.cancel_handle)
					i++;
				if (i < alarm_q.size()) begin
					e = alarm_q[i];
					alarm_q.delete(i);
					r = make_rsp(ST_CANCELLED, e.tag, e.kind, q.cancel_handle, now_t);
				end else
					r = make_rsp(ST_NOT_FOUND, 8'd0, 1'b0, q.cancel_handle, now_t);
				r.last = 1'b1;
				expected_rsp.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t w;
		if (!arst_n) begin
			alarm_q.delete();
			expected_rsp.delete();
			handle_ctr = 16'd0;
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (req_valid && req_ready)
				predict_alarm_results(req);
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0)
					report_mismatch("unexpected result", 64'(rsp.status), 64'd0);
				else begin
					w = expected_rsp.pop_front();
					if (rsp.status !== w.status)
						report_mismatch("status", 64'(rsp.status), 64'(w.status));
					if (rsp.result_tag !== w.result_tag)
						report_mismatch("tag", 64'(rsp.result_tag), 64'(w.result_tag));
					if (rsp.result_kind !== w.result_kind)
						report_mismatch("kind", 64'(rsp.result_kind), 64'(w.result_kind));
					if (rsp.result_handle !== w.result_handle)
						report_mismatch("handle", 64'(rsp.result_handle),
							64'(w.result_handle));
					if (rsp.time_sec !== w.time_sec)
						report_mismatch("time_sec", 64'(rsp.time_sec), 64'(w.time_sec));
					if (rsp.time_nsec !== w.time_nsec)
						report_mismatch("time_nsec", 64'(rsp.time_nsec), 64'(w.time_nsec));
					if (rsp.next_valid !== w.next_valid)
						report_mismatch("next_valid", 64'(rsp.next_valid), 64'(w.next_valid));
					if (rsp.next_sec !== w.next_sec)
						report_mismatch("next_sec", 64'(rsp.next_sec), 64'(w.next_sec));
					if (rsp.next_nsec !== w.next_nsec)
						report_mismatch("next_nsec", 64'(rsp.next_nsec), 64'(w.next_nsec));
					if (rsp.last !== w.last)
						report_mismatch("last", 64'(rsp.last), 64'(w.last));
				end
			end
			pending_count = expected_rsp.size();
		end
	end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import satq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int fail_count;
	int pending_count;
	// The simulated clock near which all requests keep their times, so that
	// relative alarms land in the same window and expiries really pop entries.
	logic [31:0] wall_sec;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sorted_alarm_timer_queue i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	satq_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Mostly short gaps, now and then a long one, and some runs with none.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The receiver stalls at random, independently of the request side.
	always @(posedge clk) begin
		if (arst_n)
			rsp_ready <= ($urandom_range(0, 99) < 70);
	end

	// Hold the request until the block takes it. Valid drops only for a gap;
	// a back-to-back request simply replaces the payload.
	task automatic send_request(input req_t q);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	function automatic req_t base_request(logic [1:0] cmd);
		req_t q;
		q = '0;
		q.command = cmd;
		q.now_sec = wall_sec;
		q.now_nsec = 30'($urandom_range(0, 999999999));
		q.alarm_tag = 8'($urandom_range(0, 255));
		q.alarm_kind = 1'($urandom_range(0, 1));
		q.cancel_handle = 16'($urandom_range(0, 65535));
		return q;
	endfunction

	task automatic post_timer(input logic [31:0] s, input logic [29:0] ns,
			input logic [1:0] mode);
		req_t q;
		q = base_request(CMD_POST);
		q.alarm_sec = s;
		q.alarm_nsec = ns;
		q.alarm_mode = mode;
		send_request(q);
	endtask

	task automatic expire_at(input logic [31:0] s, input logic [29:0] ns);
		req_t q;
		q = base_request(CMD_EXPIRE);
		q.now_sec = s;
		q.now_nsec = ns;
		send_request(q);
	endtask

	task automatic cancel_handle_req(input logic [15:0] h);
		req_t q;
		q = base_request(CMD_CANCEL);
		q.cancel_handle = h;
		send_request(q);
	endtask

	task automatic random_request();
		req_t q;
		int pick;
		pick = $urandom_range(0, 99);
		q = base_request(CMD_POST);
		if (pick < 50) begin
			// Well-formed relative or absolute alarm a few seconds out.
			q.alarm_mode = 2'($urandom_range(0, 1));
			if (q.alarm_mode[0])
				q.alarm_sec = $urandom_range(0, 6);
			else
				q.alarm_sec = wall_sec + $urandom_range(0, 6);
			q.alarm_nsec = 30'($urandom_range(0, 999999999));
		end else if (pick < 56) begin
			// Noise: any raw field values at all.
			q.alarm_sec = $urandom;
			q.alarm_nsec = 30'($urandom);
			q.alarm_mode = 2'($urandom);
			q.now_sec = $urandom;
			q.now_nsec = 30'($urandom);
			q.command = 2'($urandom_range(0, 3));
		end else if (pick < 78) begin
			q.command = CMD_EXPIRE;
			wall_sec = wall_sec + $urandom_range(0, 3);
			q.now_sec = wall_sec;
		end else begin
			q.command = CMD_CANCEL;
			if ($urandom_range(0, 3) != 0)
				q.cancel_handle = 16'($urandom_range(0, 40));
		end
		send_request(q);
	endtask

	initial begin
		wall_sec = 32'd100;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, each command, and the special cases.
		post_timer(32'hFFFF_FFFF, 30'd999999999, 2'b00);
		post_timer(32'd5, 30'd1000000000, 2'b00);       // nsec out of range
		post_timer(32'd5, 30'h3FFF_FFFF, 2'b01);
		post_timer(32'd500, 30'd0, 2'b10);              // reserved mode bit
		post_timer(32'd500, 30'd0, 2'b11);
		post_timer(32'd0, 30'd0, 2'b00);                // due now
		post_timer(32'd0, 30'd0, 2'b01);                // relative zero: due now
		post_timer(32'hFFFF_FFFF, 30'd999999999, 2'b01); // seconds wrap
		post_timer(32'd2, 30'd999999999, 2'b01);        // nsec carry
		post_timer(32'd200, 30'd7, 2'b00);
		post_timer(32'd200, 30'd7, 2'b00);              // equal deadline
		cancel_handle_req(16'd1);
		cancel_handle_req(16'd1);                       // miss
		cancel_handle_req(16'hFFFF);
		expire_at(32'd50, 30'd0);                       // nothing due
		begin
			req_t q;
			q = base_request(CMD_IGNORED);               // unused command
			q.alarm_mode = 2'b11;
			q.now_nsec = 30'h3FFF_FFFF;
			send_request(q);
		end
		for (int i = 0; i < 18; i++)                    // fill past full
			post_timer(32'd300, 30'($urandom_range(0, 999999999)), 2'b00);
		expire_at(32'd400, 30'h3FFF_FFFF);              // pops all but the latest entry
		expire_at(32'hFFFF_FFFF, 30'h3FFF_FFFF);
		expire_at(32'hFFFF_FFFF, 30'h3FFF_FFFF);

		wall_sec = 32'd1000;
		for (int i = 0; i < 443; i++)
			random_request();
		req_valid <= 1'b0;

		@(posedge clk);
		wait (pending_count == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
